// File: src/ansi_escape_text_terminal_macros.svh
// Assertion macros shared by the terminal RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ANSI_ESCAPE_TEXT_TERMINAL_MACROS_SVH
`define ANSI_ESCAPE_TEXT_TERMINAL_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define AETT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AETT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AETT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define AETT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/aett_pkg.sv
package aett_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ColW    = 8;
  localparam int unsigned RowW    = 6;
  localparam int unsigned AddrW   = 14;
  localparam int unsigned ColourW = 3;
  localparam int unsigned CountW  = 8;
  localparam int unsigned NumW    = 16;

  // Columns advanced by one tab stop.
  localparam int unsigned TabWidth = 8;

  localparam logic [ColW-1:0] ColsReset = 8'd80;
  localparam logic [RowW-1:0] RowsReset = 6'd24;

  localparam logic [ColourW-1:0] ForeReset = 3'd7;
  localparam logic [ColourW-1:0] BackReset = 3'd0;

  typedef enum logic [2:0] {
    ACT_CURSOR = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_CLEOL  = 3'd3,
    ACT_COLOUR = 3'd4
  } action_e;

endpackage

// File: src/aett_if.sv
// Received byte channel.
interface aett_in_if;
  import aett_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// Grid command channel.
interface aett_out_if;
  import aett_pkg::*;

  logic               valid;
  logic               ready;
  action_e            action;
  logic [AddrW-1:0]   cell_address;
  logic [CharW-1:0]   char_code;
  logic [ColourW-1:0] fore_colour;
  logic [ColourW-1:0] back_colour;
  logic [CountW-1:0]  clear_count;
  logic [RowW-1:0]    cursor_row;
  logic [ColW-1:0]    cursor_col;

  modport source (output valid, output action, output cell_address, output char_code,
                  output fore_colour, output back_colour, output clear_count,
                  output cursor_row, output cursor_col, input ready);
  modport sink   (input valid, input action, input cell_address, input char_code,
                  input fore_colour, input back_colour, input clear_count,
                  input cursor_row, input cursor_col, output ready);
endinterface

// File: src/ansi_escape_text_terminal.sv
// Channel   Dir  Payload                                         Transfer
// --------  ---  ----------------------------------------------  -----------------
// byte_i    in   byte_in                                         valid & ready
// cmd_o     out  action, cell_address, char_code, colours,       valid & ready
//                clear_count, cursor_row, cursor_col
// APB       in   columns at 0x0, rows at 0x4                     psel&penable&pwrite
//
// Each byte is held in the input register and decoded from there into the command register;
// one byte per cycle is sustained while cmd_o is ready. The decode of one byte feeds the
// parser and cursor registers used by the next, so that loop and the address multiply behind
// it set the clock.
// Reset (rst_ni low, asynchronous) clears the parser, homes the cursor, sets white on
// black and 80 x 24. A stalled cmd_o holds its command; byte_i keeps taking one more
// byte into the input register and then stalls.
module ansi_escape_text_terminal #(
  parameter int unsigned TabStep = aett_pkg::TabWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aett_in_if.sink               byte_i,
  aett_out_if.source            cmd_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import aett_pkg::*;

  `include "ansi_escape_text_terminal_macros.svh"

  // Byte codes the parser recognizes.
  localparam logic [CharW-1:0] ChEsc   = 8'd27;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChLf    = 8'd10;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChLbrk  = 8'h5B; // [
  localparam logic [CharW-1:0] ChK     = 8'h4B;
  localparam logic [CharW-1:0] ChJ     = 8'h4A;
  localparam logic [CharW-1:0] ChA     = 8'h41;
  localparam logic [CharW-1:0] ChB     = 8'h42;
  localparam logic [CharW-1:0] ChC     = 8'h43;
  localparam logic [CharW-1:0] ChD     = 8'h44;
  localparam logic [CharW-1:0] ChSemi  = 8'h3B;
  localparam logic [CharW-1:0] ChH     = 8'h48;
  localparam logic [CharW-1:0] ChM     = 8'h6D; // m
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  typedef enum logic [4:0] {
    ST_NORMAL = 5'b00001,
    ST_ESCAPE = 5'b00010,
    ST_CSI    = 5'b00100,
    ST_EXT1   = 5'b01000,
    ST_EXT2   = 5'b10000
  } parse_state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Byte address bit 2 picks the register.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] cols_q;
  logic [RowW-1:0] rows_q;
  logic            cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsReset;
      rows_q <= RowsReset;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        rows_q <= pwdata[RowW-1:0];
      end else begin
        cols_q <= pwdata[ColW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {{(32-RowW){1'b0}}, rows_q};
    end else begin
      prdata = {{(32-ColW){1'b0}}, cols_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and handshake.
  // ---------------------------------------------------------------------------
  logic             stage_valid_q;
  logic [CharW-1:0] stage_byte_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_xfer;

  // Decode the staged byte whenever the command register is free or draining.
  assign advance      = stage_valid_q & (~out_valid_q | cmd_o.ready);
  assign byte_i.ready = ~stage_valid_q | advance;
  assign in_xfer      = byte_i.valid & byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_xfer | (stage_valid_q & ~advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_byte_q <= byte_i.byte_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser and cursor state.
  // ---------------------------------------------------------------------------
  parse_state_e       st_q, st_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [NumW-1:0]    first_q, first_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [ColourW-1:0] fore_q, fore_d;
  logic [ColourW-1:0] back_q, back_d;

  // Grid size with a zero register taken as one.
  logic [ColW-1:0] nc;
  logic [RowW-1:0] nr;
  assign nc = (cols_q == '0) ? ColW'(1) : cols_q;
  assign nr = (rows_q == '0) ? RowW'(1) : rows_q;

  // Cursor pulled back into the current grid before the byte acts.
  logic [RowW-1:0] row_c;
  logic [ColW-1:0] col_c;
  assign row_c = (row_q >= nr) ? nr - RowW'(1) : row_q;
  assign col_c = (col_q > nc) ? nc : col_q;

  logic [CharW-1:0] b;
  assign b = stage_byte_q;

  logic            is_digit;
  logic            in_num;
  logic [19:0]     acc_next;
  logic [NumW-1:0] acc_sat;
  assign is_digit = (b >= ChZero) && (b <= ChNine);
  assign in_num   = (st_q == ST_CSI) || (st_q == ST_EXT1) || (st_q == ST_EXT2);
  // n*10 as two shifts; saturate once the sum leaves 16 bits.
  assign acc_next = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + {12'd0, b - ChZero};
  assign acc_sat  = (acc_next[19:NumW] != '0) ? {NumW{1'b1}} : acc_next[NumW-1:0];

  // Shared helper values.
  logic [NumW:0]   row_ext, col_ext;
  logic [ColW-1:0] col_lim;     // column held to 0..columns-1
  logic [NumW:0]   n_plus_row, n_plus_col;
  logic [RowW:0]   row_inc;
  logic [RowW-1:0] row_next;    // next row, wrapping to the top
  logic [ColW:0]   col_tab;
  logic [RowW-1:0] h_row;
  logic [ColW-1:0] h_col;
  logic [NumW:0]   nr_ext, nc_ext;

  assign row_ext    = {{(NumW+1-RowW){1'b0}}, row_c};
  assign col_ext    = {{(NumW+1-ColW){1'b0}}, col_c};
  assign nr_ext     = {{(NumW+1-RowW){1'b0}}, nr};
  assign nc_ext     = {{(NumW+1-ColW){1'b0}}, nc};
  assign col_lim    = (col_c >= nc) ? nc - ColW'(1) : col_c;
  assign n_plus_row = {1'b0, num_q} + row_ext;
  assign n_plus_col = {1'b0, num_q} + col_ext;
  assign row_inc    = {1'b0, row_c} + (RowW+1)'(1);
  assign row_next   = (row_inc >= {1'b0, nr}) ? '0 : row_inc[RowW-1:0];
  assign col_tab    = {1'b0, col_c} + (ColW+1)'(TabStep);

  // Position clamp: 1..rows and 1..columns, then zero based.
  always_comb begin
    if ({1'b0, first_q} > nr_ext) begin
      h_row = nr - RowW'(1);
    end else if (first_q == '0) begin
      h_row = '0;
    end else begin
      h_row = first_q[RowW-1:0] - RowW'(1);
    end
    if ({1'b0, num_q} > nc_ext) begin
      h_col = nc - ColW'(1);
    end else if (num_q == '0) begin
      h_col = '0;
    end else begin
      h_col = num_q[ColW-1:0] - ColW'(1);
    end
  end

  action_e          act;
  logic [CharW-1:0] ch;
  logic [CountW-1:0] cnt;
  logic [RowW-1:0]  addr_row;
  logic [ColW-1:0]  addr_col;
  logic [RowW-1:0]  row_w;
  logic [ColW-1:0]  col_w;

  // Wrap target of a cell write.
  always_comb begin
    if (col_c >= nc) begin
      row_w = row_next;
      col_w = '0;
    end else begin
      row_w = row_c;
      col_w = col_c;
    end
  end

  always_comb begin
    st_d     = st_q;
    num_d    = '0;
    first_d  = first_q;
    row_d    = row_c;
    col_d    = col_c;
    fore_d   = fore_q;
    back_d   = back_q;
    act      = ACT_CURSOR;
    ch       = '0;
    cnt      = '0;
    addr_row = row_d;
    addr_col = col_d;

    if (b == ChEsc) begin
      st_d = ST_ESCAPE;
    end else if (st_q == ST_ESCAPE && b == ChLbrk) begin
      st_d = ST_CSI;
    end else if (st_q == ST_CSI && b == ChK) begin
      st_d = ST_NORMAL;
      act  = ACT_CLEOL;
      cnt  = nc - col_c;
    end else if (in_num && is_digit) begin
      num_d = acc_sat;
    end else if (st_q == ST_CSI && num_q == NumW'(2) && b == ChJ) begin
      // Clear screen homes the cursor and restores white on black.
      st_d   = ST_NORMAL;
      row_d  = '0;
      col_d  = '0;
      fore_d = ForeReset;
      back_d = BackReset;
      act    = ACT_CLEAR;
    end else if (st_q == ST_CSI && num_q != '0 && b == ChA) begin
      st_d  = ST_NORMAL;
      row_d = ({1'b0, num_q} >= row_ext) ? '0 : row_c - num_q[RowW-1:0];
      col_d = col_lim;
    end else if (st_q == ST_CSI && num_q != '0 && b == ChB) begin
      st_d  = ST_NORMAL;
      row_d = (n_plus_row >= nr_ext) ? nr - RowW'(1) : n_plus_row[RowW-1:0];
      col_d = col_lim;
    end else if (st_q == ST_CSI && num_q != '0 && b == ChC) begin
      st_d  = ST_NORMAL;
      col_d = (n_plus_col >= nc_ext) ? nc - ColW'(1) : n_plus_col[ColW-1:0];
    end else if (st_q == ST_CSI && num_q != '0 && b == ChD) begin
      st_d  = ST_NORMAL;
      col_d = ({1'b0, num_q} >= {{(NumW+1-ColW){1'b0}}, col_lim}) ? '0
            : col_lim - num_q[ColW-1:0];
    end else if (st_q == ST_CSI && b == ChSemi) begin
      st_d    = ST_EXT1;
      first_d = num_q;
    end else if (st_q == ST_EXT1 && b == ChSemi) begin
      st_d = ST_EXT2;
    end else if (st_q == ST_EXT1 && b == ChH) begin
      st_d  = ST_NORMAL;
      row_d = h_row;
      col_d = h_col;
    end else if (st_q == ST_EXT1 && b == ChM) begin
      // Out-of-range colour codes fall back to white on black.
      st_d   = ST_NORMAL;
      fore_d = (first_q >= NumW'(30) && first_q <= NumW'(37))
             ? ColourW'(first_q - NumW'(30)) : ForeReset;
      back_d = (num_q >= NumW'(40) && num_q <= NumW'(47))
             ? ColourW'(num_q - NumW'(40)) : BackReset;
      act    = ACT_COLOUR;
    end else if (st_q == ST_NORMAL && b == ChCr) begin
      col_d = '0;
    end else if (st_q == ST_NORMAL && b == ChLf) begin
      // Line feed on the last row scrolls by clearing the screen.
      if (row_inc >= {1'b0, nr}) begin
        row_d  = '0;
        col_d  = '0;
        fore_d = ForeReset;
        back_d = BackReset;
        act    = ACT_CLEAR;
      end else begin
        row_d = row_inc[RowW-1:0];
        col_d = '0;
      end
    end else if (st_q == ST_NORMAL && b == ChTab) begin
      if (col_tab >= {1'b0, nc}) begin
        row_d = row_next;
        col_d = '0;
      end else begin
        col_d = col_tab[ColW-1:0];
      end
    end else begin
      // Anything else is a character: write it at the (wrapped) cursor.
      row_d = row_w;
      col_d = col_w + ColW'(1);
      act   = ACT_WRITE;
      ch    = b;
    end

    // A write addresses the cell before the cursor steps on.
    if (act == ACT_WRITE) begin
      addr_row = row_w;
      addr_col = col_w;
    end else begin
      addr_row = row_d;
      addr_col = col_d;
    end
  end

  // Cell address: row * (columns + 1) + column, kept to 14 bits.
  logic [ColW:0]        pitch;
  logic [RowW+ColW:0]   row_base;
  logic [RowW+ColW+1:0] addr_full;
  assign pitch     = {1'b0, nc} + (ColW+1)'(1);
  assign row_base  = {{(ColW+1){1'b0}}, addr_row} * {{RowW{1'b0}}, pitch};
  assign addr_full = {1'b0, row_base} + {{(RowW+2){1'b0}}, addr_col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_NORMAL;
      num_q   <= '0;
      first_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      fore_q  <= ForeReset;
      back_q  <= BackReset;
    end else if (advance) begin
      st_q    <= st_d;
      num_q   <= num_d;
      first_q <= first_d;
      row_q   <= row_d;
      col_q   <= col_d;
      fore_q  <= fore_d;
      back_q  <= back_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Command register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance | (out_valid_q & ~cmd_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_o.action       <= act;
      cmd_o.cell_address <= addr_full[AddrW-1:0];
      cmd_o.char_code    <= ch;
      cmd_o.fore_colour  <= fore_d;
      cmd_o.back_colour  <= back_d;
      cmd_o.clear_count  <= cnt;
      cmd_o.cursor_row   <= row_d;
      cmd_o.cursor_col   <= col_d;
    end
  end

  assign cmd_o.valid = out_valid_q;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `AETT_ASSERT_NXT(a_stage_hold, clk_i, rst_ni, stage_valid_q && !advance,
                   stage_valid_q, "staged byte dropped while output stalled")
  `AETT_ASSERT_IMP(a_clear_home, clk_i, rst_ni,
                   out_valid_q && cmd_o.action == ACT_CLEAR,
                   cmd_o.cursor_row == '0 && cmd_o.cursor_col == '0 &&
                   cmd_o.fore_colour == ForeReset && cmd_o.back_colour == BackReset &&
                   cmd_o.cell_address == '0, "clear screen did not home the cursor")
  `AETT_ASSERT_IMP(a_count_cleol, clk_i, rst_ni,
                   out_valid_q && cmd_o.action != ACT_CLEOL,
                   cmd_o.clear_count == '0, "clear count set outside clear to line end")
  `AETT_ASSERT_IMP(a_char_write, clk_i, rst_ni,
                   out_valid_q && cmd_o.action != ACT_WRITE,
                   cmd_o.char_code == '0, "character code set outside a cell write")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import aett_pkg::*;

  // Run shape.
  localparam int unsigned PhaseItems  = 100;  // bytes per grid setting
  localparam int unsigned Phases      = 7;
  localparam int unsigned PauseCycles = 4;    // settle time before a register write
  localparam int unsigned DrainCycles = 10;   // quiet time after the last command
  localparam int unsigned Watchdog    = 1000; // cycles without any transfer

  // Register byte addresses.
  localparam logic [2:0] REG_COLUMNS = 3'h0;
  localparam logic [2:0] REG_ROWS    = 3'h4;

  // Bytes the parser reacts to.
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_LBRACK  = "[";
  localparam logic [7:0] CH_SEMI    = ";";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UP      = "A";
  localparam logic [7:0] CH_DOWN    = "B";
  localparam logic [7:0] CH_RIGHT   = "C";
  localparam logic [7:0] CH_LEFT    = "D";
  localparam logic [7:0] CH_HOME    = "H";
  localparam logic [7:0] CH_ERASE   = "J";
  localparam logic [7:0] CH_ERASEOL = "K";
  localparam logic [7:0] CH_SGR     = "m";

  // Escape parser states of the predictor.
  typedef enum logic [2:0] {
    PS_NORMAL = 3'd0,
    PS_ESCAPE = 3'd1,
    PS_CSI    = 3'd2,
    PS_PARAM1 = 3'd3,
    PS_PARAM2 = 3'd4
  } parse_e;

  // One grid command as seen on cmd_o.
  typedef struct packed {
    action_e            action;
    logic [AddrW-1:0]   cell_address;
    logic [CharW-1:0]   char_code;
    logic [ColourW-1:0] fore_colour;
    logic [ColourW-1:0] back_colour;
    logic [CountW-1:0]  clear_count;
    logic [RowW-1:0]    cursor_row;
    logic [ColW-1:0]    cursor_col;
  } grid_cmd_t;

  localparam grid_cmd_t NO_CMD = grid_cmd_t'(0);

  // A byte plus, where it is obvious, the command it must produce.
  typedef struct packed {
    logic       typed;
    grid_cmd_t  want;
  } cmd_hint_t;

  typedef struct packed {
    logic [7:0] stim;
    logic       typed;
    grid_cmd_t  want;
  } dir_row_t;

  // Directed sequence, starting from reset (80 x 24, white on black, cursor home).
  localparam int unsigned DirRows = 34;
  localparam dir_row_t DIR_TABLE [DirRows] = '{
    // plain character at home, then ESC [ K clears the rest of row 0
    '{CH_UP,      1'b1, '{ACT_WRITE,  14'd0, CH_UP, 3'd7, 3'd0, 8'd0,  6'd0, 8'd1}},
    '{CH_ESC,     1'b1, '{ACT_CURSOR, 14'd1, 8'd0, 3'd7, 3'd0, 8'd0,  6'd0, 8'd1}},
    '{CH_LBRACK,  1'b1, '{ACT_CURSOR, 14'd1, 8'd0, 3'd7, 3'd0, 8'd0,  6'd0, 8'd1}},
    '{CH_ERASEOL, 1'b1, '{ACT_CLEOL,  14'd1, 8'd0, 3'd7, 3'd0, 8'd79, 6'd0, 8'd1}},
    // ESC [ 2 J clears the screen and homes the cursor
    '{CH_ESC,     1'b0, NO_CMD},
    '{CH_LBRACK,  1'b0, NO_CMD},
    '{"2",        1'b0, NO_CMD},
    '{CH_ERASE,   1'b1, '{ACT_CLEAR,  14'd0, 8'd0, 3'd7, 3'd0, 8'd0,  6'd0, 8'd0}},
    // ESC [ 31 ; 44 m selects red on blue
    '{CH_ESC,     1'b0, NO_CMD},
    '{CH_LBRACK,  1'b0, NO_CMD},
    '{"3",        1'b0, NO_CMD},
    '{"1",        1'b0, NO_CMD},
    '{CH_SEMI,    1'b0, NO_CMD},
    '{"4",        1'b0, NO_CMD},
    '{"4",        1'b0, NO_CMD},
    '{CH_SGR,     1'b1, '{ACT_COLOUR, 14'd0, 8'd0, 3'd1, 3'd4, 8'd0,  6'd0, 8'd0}},
    // ESC [ ; 999 H clamps to the last column of row 0
    '{CH_ESC,     1'b0, NO_CMD},
    '{CH_LBRACK,  1'b0, NO_CMD},
    '{CH_SEMI,    1'b0, NO_CMD},
    '{CH_NINE,    1'b0, NO_CMD},
    '{CH_NINE,    1'b0, NO_CMD},
    '{CH_NINE,    1'b0, NO_CMD},
    '{CH_HOME,    1'b0, NO_CMD},
    // fill the last cell, then wrap onto the next row; tab, return, line feed
    '{8'hFF,      1'b0, NO_CMD},
    '{8'h00,      1'b0, NO_CMD},
    '{CH_TAB,     1'b0, NO_CMD},
    '{CH_CR,      1'b0, NO_CMD},
    '{CH_LF,      1'b0, NO_CMD},
    // a move without count is written as text; then a third parameter field
    '{CH_ESC,     1'b0, NO_CMD},
    '{CH_LBRACK,  1'b0, NO_CMD},
    '{CH_UP,      1'b0, NO_CMD},
    '{CH_SEMI,    1'b0, NO_CMD},
    '{CH_SEMI,    1'b0, NO_CMD},
    '{"x",        1'b0, NO_CMD}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  // Configuration port.
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  aett_in_if  byte_if ();
  aett_out_if cmd_if ();

  ansi_escape_text_terminal u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .cmd_o   (cmd_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: grid size, parser and cursor, mirrored from reset.
  logic [ColW-1:0]    grid_cols  = ColsReset;
  logic [RowW-1:0]    grid_rows  = RowsReset;
  parse_e             pstate     = PS_NORMAL;
  logic [NumW-1:0]    num_acc    = '0;
  logic [NumW-1:0]    lead_param = '0;
  logic [RowW-1:0]    cur_row    = '0;
  logic [ColW-1:0]    cur_col    = '0;
  logic [ColourW-1:0] fg         = ForeReset;
  logic [ColourW-1:0] bg         = BackReset;

  cmd_hint_t   hint_q [$];       // one per byte offered, in order
  grid_cmd_t   grid_cmd_q [$];   // commands owed by the block
  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cmds_checked  = 0;
  int unsigned grid_settings = 1;
  int unsigned stall_cycles  = 0;
  int unsigned ready_left    = 0;
  bit          no_idle       = 1'b0;

  function automatic logic [AddrW-1:0] cell_index(input int unsigned r, input int unsigned c,
                                                  input int unsigned nc);
    return AddrW'(r * (nc + 1) + c);
  endfunction

  // Advance the predictor by one received byte and return the command it yields.
  function automatic grid_cmd_t decode_byte(input logic [7:0] b);
    grid_cmd_t   r;
    int unsigned nc, nr, n, v, row, col, pr, pc;
    bit          in_num, addr_done;
    nc  = (grid_cols == 0) ? 1 : grid_cols;
    nr  = (grid_rows == 0) ? 1 : grid_rows;
    n   = num_acc;
    row = cur_row;
    col = cur_col;
    r   = NO_CMD;
    r.action  = ACT_CURSOR;
    addr_done = 1'b0;
    in_num = (pstate == PS_CSI) || (pstate == PS_PARAM1) || (pstate == PS_PARAM2);

    // pull the cursor back inside a grid that may have shrunk
    if (row >= nr) row = nr - 1;
    if (col > nc) col = nc;

    if (b == CH_ESC) begin
      pstate  = PS_ESCAPE;
      num_acc = '0;
    end else if (pstate == PS_ESCAPE && b == CH_LBRACK) begin
      pstate  = PS_CSI;
      num_acc = '0;
    end else if (pstate == PS_CSI && b == CH_ERASEOL) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      r.action       = ACT_CLEOL;
      r.cell_address = cell_index(row, col, nc);
      r.clear_count  = CountW'(nc - col);
      addr_done      = 1'b1;
    end else if (in_num && b >= CH_ZERO && b <= CH_NINE) begin
      // saturate the decimal count at its full width
      v = n * 10 + (b - CH_ZERO);
      num_acc = (v > 65535) ? 16'hFFFF : v[NumW-1:0];
    end else if (pstate == PS_CSI && n == 2 && b == CH_ERASE) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      row = 0;
      col = 0;
      fg  = ForeReset;
      bg  = BackReset;
      r.action  = ACT_CLEAR;
      addr_done = 1'b1;
    end else if (pstate == PS_CSI && n > 0 && b == CH_UP) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      row = (n >= row) ? 0 : row - n;
      if (col >= nc) col = nc - 1;
    end else if (pstate == PS_CSI && n > 0 && b == CH_DOWN) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      row = (row + n >= nr) ? nr - 1 : row + n;
      if (col >= nc) col = nc - 1;
    end else if (pstate == PS_CSI && n > 0 && b == CH_RIGHT) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      col = (col + n >= nc) ? nc - 1 : col + n;
    end else if (pstate == PS_CSI && n > 0 && b == CH_LEFT) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      if (col >= nc) col = nc - 1;
      col = (n >= col) ? 0 : col - n;
    end else if (pstate == PS_CSI && b == CH_SEMI) begin
      pstate     = PS_PARAM1;
      lead_param = n[NumW-1:0];
      num_acc    = '0;
    end else if (pstate == PS_PARAM1 && b == CH_SEMI) begin
      pstate  = PS_PARAM2;
      num_acc = '0;
    end else if (pstate == PS_PARAM1 && b == CH_HOME) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      pr = lead_param;
      pc = n;
      if (pr > nr) pr = nr;
      if (pr < 1) pr = 1;
      if (pc > nc) pc = nc;
      if (pc < 1) pc = 1;
      row = pr - 1;
      col = pc - 1;
    end else if (pstate == PS_PARAM1 && b == CH_SGR) begin
      pstate  = PS_NORMAL;
      num_acc = '0;
      fg = (lead_param >= 30 && lead_param <= 37) ? ColourW'(lead_param - 30) : ForeReset;
      bg = (n >= 40 && n <= 47) ? ColourW'(n - 40) : BackReset;
      r.action = ACT_COLOUR;
    end else if (pstate == PS_NORMAL && b == CH_CR) begin
      num_acc = '0;
      col = 0;
    end else if (pstate == PS_NORMAL && b == CH_LF) begin
      num_acc = '0;
      // a line feed on the last row scrolls by clearing the screen
      if (row + 1 >= nr) begin
        row = 0;
        col = 0;
        fg  = ForeReset;
        bg  = BackReset;
        r.action  = ACT_CLEAR;
        addr_done = 1'b1;
      end else begin
        row = row + 1;
        col = 0;
      end
    end else if (pstate == PS_NORMAL && b == CH_TAB) begin
      num_acc = '0;
      if (col + TabWidth >= nc) begin
        row = (row + 1 >= nr) ? 0 : row + 1;
        col = 0;
      end else begin
        col = col + TabWidth;
      end
    end else begin
      // anything else is text; a pending wrap moves to the next row first
      num_acc = '0;
      if (col >= nc) begin
        row = (row + 1 >= nr) ? 0 : row + 1;
        col = 0;
      end
      r.action       = ACT_WRITE;
      r.cell_address = cell_index(row, col, nc);
      r.char_code    = b;
      addr_done      = 1'b1;
      col = col + 1;
    end

    if (!addr_done) r.cell_address = cell_index(row, col, nc);
    cur_row = RowW'(row);
    cur_col = ColW'(col);
    r.fore_colour = fg;
    r.back_colour = bg;
    r.cursor_row  = cur_row;
    r.cursor_col  = cur_col;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Predict on every byte transfer and check every command transfer.
  always @(posedge clk_i) begin : monitor
    cmd_hint_t hint;
    grid_cmd_t model, want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        hint  = hint_q.pop_front();
        model = decode_byte(byte_if.byte_in);
        // a typed row overrides the predictor; the predictor still advances
        grid_cmd_q.push_back(hint.typed ? hint.want : model);
      end
      if (cmd_if.valid && cmd_if.ready) begin
        if (grid_cmd_q.size() == 0) begin
          $error("grid command with no byte behind it: action %0d", cmd_if.action);
          errors++;
        end else begin
          want = grid_cmd_q.pop_front();
          check_field("action",       32'(want.action),       32'(cmd_if.action));
          check_field("cell_address", 32'(want.cell_address), 32'(cmd_if.cell_address));
          check_field("char_code",    32'(want.char_code),    32'(cmd_if.char_code));
          check_field("fore_colour",  32'(want.fore_colour),  32'(cmd_if.fore_colour));
          check_field("back_colour",  32'(want.back_colour),  32'(cmd_if.back_colour));
          check_field("clear_count",  32'(want.clear_count),  32'(cmd_if.clear_count));
          check_field("cursor_row",   32'(want.cursor_row),   32'(cmd_if.cursor_row));
          check_field("cursor_col",   32'(want.cursor_col),   32'(cmd_if.cursor_col));
          cmds_checked++;
        end
      end
    end
  end

  // Drop ready for random bursts and raise it for random open stretches.
  always @(posedge clk_i) begin
    if (no_idle) begin
      cmd_if.ready <= 1'b1;
      ready_left   <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      cmd_if.ready <= 1'b0;
      ready_left   <= $urandom_range(0, 15);
    end else begin
      cmd_if.ready <= 1'b1;
      ready_left   <= $urandom_range(0, 24);
    end
  end

  // End the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (byte_if.valid && byte_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= Watchdog) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one byte and hold it until the transfer; valid stays high for the next byte.
  task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input grid_cmd_t want = NO_CMD);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    hint_q.push_back('{typed: typed, want: want});
    byte_if.valid   <= 1'b1;
    byte_if.byte_in <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_number(input int unsigned v);
    string digits;
    int    i;
    digits = $sformatf("%0d", v);
    // an empty parameter field reads as zero too
    if (v == 0 && $urandom_range(0, 1) == 0) return;
    for (i = 0; i < digits.len(); i++) push_byte(digits[i]);
  endtask

  function automatic int unsigned pick_number();
    int unsigned span;
    span = ((grid_cols > grid_rows) ? grid_cols : grid_rows) + 2;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 99999);
      1, 2:    return $urandom_range(0, 9);
      default: return $urandom_range(1, span);
    endcase
  endfunction

  // Send one random group: mostly well-formed sequences, some noise and broken ones.
  task automatic send_random_group();
    int unsigned pick;
    logic [7:0]  fin;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(32, 126)));
    end else if (pick < 50) begin
      case ($urandom_range(0, 5))
        0:       fin = CH_UP;
        1:       fin = CH_DOWN;
        2:       fin = CH_RIGHT;
        3:       fin = CH_LEFT;
        4:       fin = CH_ERASEOL;
        default: fin = CH_ERASE;
      endcase
      push_byte(CH_ESC);
      push_byte(CH_LBRACK);
      send_number((fin == CH_ERASE && $urandom_range(0, 3) != 0) ? 2 : pick_number());
      push_byte(fin);
    end else if (pick < 62) begin
      push_byte(CH_ESC);
      push_byte(CH_LBRACK);
      send_number(pick_number());
      push_byte(CH_SEMI);
      send_number(pick_number());
      push_byte(CH_HOME);
    end else if (pick < 72) begin
      push_byte(CH_ESC);
      push_byte(CH_LBRACK);
      send_number($urandom_range(0, 3) != 0 ? $urandom_range(28, 39) : pick_number());
      push_byte(CH_SEMI);
      send_number($urandom_range(0, 3) != 0 ? $urandom_range(38, 49) : pick_number());
      push_byte(CH_SGR);
    end else if (pick < 84) begin
      case ($urandom_range(0, 2))
        0:       push_byte(CH_CR);
        1:       push_byte(CH_LF);
        default: push_byte(CH_TAB);
      endcase
    end else if (pick < 94) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      // cut a sequence short or run it into a third parameter field
      push_byte(CH_ESC);
      if ($urandom_range(0, 1) == 0) push_byte(CH_LBRACK);
      send_number(pick_number());
      if ($urandom_range(0, 1) == 0) begin
        push_byte(CH_SEMI);
        send_number(pick_number());
        push_byte(CH_SEMI);
        send_number(pick_number());
      end
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // APB write: setup, then access until pready.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_COLUMNS) grid_cols = data[ColW-1:0];
    else grid_rows = data[RowW-1:0];
  endtask

  // Hold the byte stream until every command is back, then resize the grid.
  task automatic set_grid(input logic [ColW-1:0] cols, input logic [RowW-1:0] nrows);
    byte_if.valid <= 1'b0;
    while (grid_cmd_q.size() != 0 || hint_q.size() != 0) @(posedge clk_i);
    repeat (PauseCycles) @(posedge clk_i);
    reg_write(REG_COLUMNS, 32'(cols));
    reg_write(REG_ROWS, 32'(nrows));
    grid_settings++;
  endtask

  initial begin
    int unsigned phase, sent_mark, i;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    byte_if.valid   <= 1'b0;
    byte_if.byte_in <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table from the reset grid.
    for (i = 0; i < DirRows; i++) begin
      push_byte(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    // Random part: one phase per grid setting, extremes included.
    for (phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: ;  // stay on the reset grid
        1: set_grid(8'd1, 6'd1);
        2: set_grid(8'd255, 6'd63);
        3: set_grid(8'd0, 6'd0);
        4: set_grid(ColW'($urandom_range(2, 254)), RowW'($urandom_range(2, 62)));
        5: set_grid(8'd255, 6'd1);
        default: set_grid(ColW'($urandom_range(1, 12)), RowW'($urandom_range(1, 63)));
      endcase
      // run one middle phase and the last one at full rate
      no_idle   = (phase == 3) || (phase == Phases - 1);
      sent_mark = bytes_sent;
      while (bytes_sent - sent_mark < PhaseItems) send_random_group();
    end

    byte_if.valid <= 1'b0;
    while (grid_cmd_q.size() != 0 || hint_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (grid_cmd_q.size() != 0) begin
      $error("%0d grid commands never came out", grid_cmd_q.size());
      errors++;
    end

    $display("Sent %0d bytes over %0d grid sizes; %0d grid commands checked, %0d errors.",
             bytes_sent, grid_settings, cmds_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/aett_pkg.sv
src/aett_if.sv
src/ansi_escape_text_terminal.sv
tb/sv/tb_top.sv
